// ----- rtl/rtu_frame_validate_dispatch_top_defines.svh -----
// ----------------------------------------------------------------------------
// RTU frame validate and dispatch: assertion macros
// Shared concurrent assertion macros. They expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef RTU_FRAME_VALIDATE_DISPATCH_TOP_DEFINES_SVH
`define RTU_FRAME_VALIDATE_DISPATCH_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define RFVD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define RFVD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define RFVD_ASSERT(lbl, prop, msg)

`define RFVD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/rfvd_pkg.sv -----
// ----------------------------------------------------------------------------
// RTU frame validate and dispatch: package
// Word types, status and action codes, and the CRC-16 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package rfvd_pkg;

  localparam int BUFFER_BYTES_DEF = 256;
  localparam int QUEUE_DEPTH      = 2;
  localparam int MIN_FRAME        = 6;
  localparam int CFG_INDEX_W      = 8;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ID = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CONFIG_ID = 8'd1;
  localparam logic [7:0] DEVICE_ID_RST = 8'd1;
  localparam logic [7:0] CONFIG_ID_RST = 8'd255;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_EOF  = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_TX     = 1'b1;

  localparam logic [2:0] ST_ACCEPTED   = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
  localparam logic [2:0] ST_CRC_ERR    = 3'd2;
  localparam logic [2:0] ST_NOT_ADDR   = 3'd3;
  localparam logic [2:0] ST_BAD_FUNC   = 3'd4;

  localparam logic [1:0] AK_OWN       = 2'd0;
  localparam logic [1:0] AK_BROADCAST = 2'd1;
  localparam logic [1:0] AK_CONFIG    = 2'd2;

  localparam logic [3:0] ACT_NONE         = 4'd0;
  localparam logic [3:0] ACT_READ_COILS   = 4'd1;
  localparam logic [3:0] ACT_WR_COIL      = 4'd2;
  localparam logic [3:0] ACT_WR_COILS     = 4'd3;
  localparam logic [3:0] ACT_READ_HOLD    = 4'd4;
  localparam logic [3:0] ACT_WR_HOLD      = 4'd5;
  localparam logic [3:0] ACT_WR_HOLDS     = 4'd6;
  localparam logic [3:0] ACT_READ_DISC    = 4'd7;
  localparam logic [3:0] ACT_READ_INPUT   = 4'd8;
  localparam logic [3:0] ACT_EXCEPTION    = 4'd9;
  localparam logic [3:0] ACT_CFG_READ     = 4'd10;
  localparam logic [3:0] ACT_CFG_WRITE    = 4'd11;

  localparam logic [7:0] FC_READ_COILS  = 8'd1;
  localparam logic [7:0] FC_READ_DISC   = 8'd2;
  localparam logic [7:0] FC_READ_HOLD   = 8'd3;
  localparam logic [7:0] FC_READ_INPUT  = 8'd4;
  localparam logic [7:0] FC_WR_COIL     = 8'd5;
  localparam logic [7:0] FC_WR_HOLD     = 8'd6;
  localparam logic [7:0] FC_WR_COILS    = 8'd15;
  localparam logic [7:0] FC_WR_HOLDS    = 8'd16;

  localparam logic [7:0] BROADCAST_ADDR = 8'h00;
  localparam logic [7:0] EXC_FLAG       = 8'h80;
  localparam logic [7:0] EXC_ILLEGAL_FC = 8'h01;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] status;
    logic [7:0] function_code;
    logic [1:0] address_kind;
    logic [3:0] action;
    logic [7:0] tx_byte;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] function_code;
    logic [1:0] address_kind;
    logic [3:0] action;
    logic       reply;
    logic [7:0] address;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rfvd_front.sv -----
// ----------------------------------------------------------------------------
// RTU frame validate and dispatch: front end
// Collects frame bytes, keeps the running CRC and classifies each frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module rfvd_front #(
  parameter int BUFFER_BYTES = rfvd_pkg::BUFFER_BYTES_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire rfvd_pkg::in_word_t             in_data,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [rfvd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire [7:0]                           cfg_data,
  input  wire rfvd_pkg::queue_stat_t          q_stat,
  output logic                                push,
  output rfvd_pkg::frame_rec_t                push_rec
);

  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam logic [CW-1:0] BUF_CNT = CW'(BUFFER_BYTES);
  localparam logic [CW-1:0] MIN_CNT = CW'(rfvd_pkg::MIN_FRAME);

  logic [7:0]    device_id_r, config_id_r;
  logic [15:0]   crc_r, crc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    addr_r, func_r, older_r, newer_r;
  logic          take, take_byte, take_eof;
  logic [7:0]    fc;
  logic          is_cfg, is_bc, addr_ok, fc_bad, crc_ok;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_stat.full;
  assign take      = in_valid && !in_stall;
  assign take_byte = take && (in_data.mode == rfvd_pkg::MODE_BYTE) && (cnt_r < BUF_CNT);
  assign take_eof  = take && (in_data.mode == rfvd_pkg::MODE_EOF);
  assign push      = take_eof && (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r <= rfvd_pkg::DEVICE_ID_RST;
      config_id_r <= rfvd_pkg::CONFIG_ID_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rfvd_pkg::REG_DEVICE_ID) device_id_r <= cfg_data;
      if (cfg_index == rfvd_pkg::REG_CONFIG_ID) config_id_r <= cfg_data;
    end
  end

  always_comb begin
    crc_nxt = crc_r;
    cnt_nxt = cnt_r;
    if (take_eof) begin
      crc_nxt = rfvd_pkg::CRC_INIT;
      cnt_nxt = '0;
    end else if (take_byte) begin
      if (cnt_r >= CW'(2)) crc_nxt = rfvd_pkg::crc_feed(crc_r, older_r);
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= rfvd_pkg::CRC_INIT;
      cnt_r <= '0;
    end else begin
      crc_r <= crc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_byte) begin
      if (cnt_r == CW'(0)) addr_r <= in_data.data_byte;
      if (cnt_r == CW'(1)) func_r <= in_data.data_byte;
      older_r <= newer_r;
      newer_r <= in_data.data_byte;
    end
  end

  assign fc      = (cnt_r >= CW'(2)) ? func_r : 8'h00;
  assign crc_ok  = (crc_r == {newer_r, older_r});
  assign is_cfg  = (addr_r == config_id_r);
  assign is_bc   = (addr_r == rfvd_pkg::BROADCAST_ADDR);
  assign addr_ok = (addr_r == device_id_r) || is_bc || is_cfg;
  assign fc_bad  = (func_r == 8'h00) || func_r[7];

  always_comb begin
    push_rec               = '0;
    push_rec.function_code = fc;
    push_rec.address       = addr_r;
    push_rec.address_kind  = rfvd_pkg::AK_OWN;
    push_rec.action        = rfvd_pkg::ACT_NONE;
    push_rec.reply         = 1'b0;
    if (cnt_r < MIN_CNT) begin
      push_rec.status = rfvd_pkg::ST_TOO_SHORT;
    end else if (!crc_ok) begin
      push_rec.status = rfvd_pkg::ST_CRC_ERR;
    end else if (!addr_ok) begin
      push_rec.status = rfvd_pkg::ST_NOT_ADDR;
    end else if (fc_bad) begin
      push_rec.status = rfvd_pkg::ST_BAD_FUNC;
    end else begin
      push_rec.status = rfvd_pkg::ST_ACCEPTED;
      if (is_cfg) begin
        push_rec.address_kind = rfvd_pkg::AK_CONFIG;
        if (fc == rfvd_pkg::FC_READ_HOLD) begin
          push_rec.action = rfvd_pkg::ACT_CFG_READ;
        end else if (fc == rfvd_pkg::FC_WR_HOLDS) begin
          push_rec.action = rfvd_pkg::ACT_CFG_WRITE;
        end else begin
          push_rec.action = rfvd_pkg::ACT_EXCEPTION;
          push_rec.reply  = 1'b1;
        end
      end else begin
        push_rec.address_kind = is_bc ? rfvd_pkg::AK_BROADCAST : rfvd_pkg::AK_OWN;
        case (fc)
          rfvd_pkg::FC_READ_COILS: begin
            push_rec.action = is_bc ? rfvd_pkg::ACT_NONE : rfvd_pkg::ACT_READ_COILS;
          end
          rfvd_pkg::FC_WR_COIL:    push_rec.action = rfvd_pkg::ACT_WR_COIL;
          rfvd_pkg::FC_WR_COILS:   push_rec.action = rfvd_pkg::ACT_WR_COILS;
          rfvd_pkg::FC_READ_HOLD: begin
            push_rec.action = is_bc ? rfvd_pkg::ACT_NONE : rfvd_pkg::ACT_READ_HOLD;
          end
          rfvd_pkg::FC_WR_HOLD:    push_rec.action = rfvd_pkg::ACT_WR_HOLD;
          rfvd_pkg::FC_WR_HOLDS:   push_rec.action = rfvd_pkg::ACT_WR_HOLDS;
          rfvd_pkg::FC_READ_DISC: begin
            push_rec.action = is_bc ? rfvd_pkg::ACT_NONE : rfvd_pkg::ACT_READ_DISC;
          end
          rfvd_pkg::FC_READ_INPUT: begin
            push_rec.action = is_bc ? rfvd_pkg::ACT_NONE : rfvd_pkg::ACT_READ_INPUT;
          end
          default: begin
            push_rec.action = rfvd_pkg::ACT_EXCEPTION;
            push_rec.reply  = !is_bc;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rfvd_queue.sv -----
// ----------------------------------------------------------------------------
// RTU frame validate and dispatch: frame queue
// Short FIFO of classified frame records between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rtu_frame_validate_dispatch_top_defines.svh"

module rfvd_queue (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        push,
  input  wire rfvd_pkg::frame_rec_t  push_rec,
  input  wire                        pop,
  output rfvd_pkg::frame_rec_t       pop_rec,
  output rfvd_pkg::queue_stat_t      q_stat
);

  localparam int DEPTH = rfvd_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  rfvd_pkg::frame_rec_t entry_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;

  assign q_stat.full  = (cnt_r == CNTW'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_rec      = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  `RFVD_ASSERT(a_no_overflow, push |-> !q_stat.full, "push into a full frame queue")
  `RFVD_ASSERT(a_no_underflow, pop |-> !q_stat.empty, "pop from an empty frame queue")
  `RFVD_ASSERT_NEXT(a_cnt_step, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "queue count slip")

endmodule

`default_nettype wire

// ----- rtl/rfvd_back.sv -----
// ----------------------------------------------------------------------------
// RTU frame validate and dispatch: back end
// Emits the frame status word and, for exceptions that call for a reply, the five reply bytes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rtu_frame_validate_dispatch_top_defines.svh"

module rfvd_back (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire rfvd_pkg::queue_stat_t  q_stat,
  input  wire rfvd_pkg::frame_rec_t   pop_rec,
  output logic                        pop,
  output logic                        out_valid,
  input  wire                         out_stall,
  output rfvd_pkg::out_word_t         out_data
);

  localparam logic [2:0] BEAT_STATUS  = 3'd0;
  localparam logic [2:0] BEAT_ADDR    = 3'd1;
  localparam logic [2:0] BEAT_FUNC    = 3'd2;
  localparam logic [2:0] BEAT_CODE    = 3'd3;
  localparam logic [2:0] BEAT_CRC_LO  = 3'd4;
  localparam logic [2:0] BEAT_CRC_HI  = 3'd5;

  logic [2:0]  beat_r, beat_nxt;
  logic        out_valid_r, out_valid_nxt;
  rfvd_pkg::out_word_t out_data_r, out_data_nxt;
  logic [7:0]  ex_addr_r, ex_func_r;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  feed_byte;
  logic        load;

  assign load      = !out_valid_r || !out_stall;
  assign pop       = load && (beat_r == BEAT_STATUS) && !q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    case (beat_r)
      BEAT_ADDR: feed_byte = ex_addr_r;
      BEAT_FUNC: feed_byte = ex_func_r;
      default:   feed_byte = rfvd_pkg::EXC_ILLEGAL_FC;
    endcase
  end

  always_comb begin
    beat_nxt      = beat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    crc_nxt       = crc_r;
    if (load) begin
      out_data_nxt      = '0;
      out_data_nxt.kind = rfvd_pkg::KIND_TX;
      case (beat_r)
        BEAT_STATUS: begin
          if (!q_stat.empty) begin
            out_valid_nxt              = 1'b1;
            out_data_nxt.kind          = rfvd_pkg::KIND_STATUS;
            out_data_nxt.status        = pop_rec.status;
            out_data_nxt.function_code = pop_rec.function_code;
            out_data_nxt.address_kind  = pop_rec.address_kind;
            out_data_nxt.action        = pop_rec.action;
            out_data_nxt.last          = !pop_rec.reply;
            crc_nxt                    = rfvd_pkg::CRC_INIT;
            if (pop_rec.reply) beat_nxt = BEAT_ADDR;
          end
        end
        BEAT_ADDR, BEAT_FUNC, BEAT_CODE: begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.tx_byte = feed_byte;
          crc_nxt              = rfvd_pkg::crc_feed(crc_r, feed_byte);
          beat_nxt             = beat_r + 3'd1;
        end
        BEAT_CRC_LO: begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.tx_byte = crc_r[7:0];
          beat_nxt             = BEAT_CRC_HI;
        end
        BEAT_CRC_HI: begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.tx_byte = crc_r[15:8];
          out_data_nxt.last    = 1'b1;
          beat_nxt             = BEAT_STATUS;
        end
        default: begin
          out_valid_nxt = 1'b0;
          beat_nxt      = BEAT_STATUS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r      <= BEAT_STATUS;
      out_valid_r <= 1'b0;
    end else begin
      beat_r      <= beat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    crc_r      <= crc_nxt;
    if (pop) begin
      ex_addr_r <= pop_rec.address;
      ex_func_r <= pop_rec.function_code | rfvd_pkg::EXC_FLAG;
    end
  end

  `RFVD_ASSERT(a_beat_range, beat_r <= BEAT_CRC_HI, "reply beat out of range")
  `RFVD_ASSERT(a_pop_idle, pop |-> (beat_r == BEAT_STATUS), "frame popped during a reply")
  `RFVD_ASSERT(a_status_last, (out_valid_r && out_data_r.kind == rfvd_pkg::KIND_STATUS) |-> (out_data_r.last == (beat_r == BEAT_STATUS)), "status last flag disagrees with reply")
  `RFVD_ASSERT(a_tx_last, (out_valid_r && out_data_r.kind == rfvd_pkg::KIND_TX) |-> (out_data_r.last == (beat_r == BEAT_STATUS)), "reply byte last flag misplaced")

endmodule

`default_nettype wire

// ----- rtl/rtu_frame_validate_dispatch_top.sv -----
// ----------------------------------------------------------------------------
// RTU frame validate and dispatch: top level
// Checks received RTU frames and dispatches a status word and any exception reply.
// ----------------------------------------------------------------------------
// Received bytes never produce a word. Input items, bytes and end of frame
// markers alike, are taken one per clock while the two-entry frame queue has
// room and are stalled while it is full. Each non-empty frame end yields one
// status word, or a status word followed by five exception reply bytes, sent
// from the output register at one word per cycle while out_stall is low; a
// frame that draws an exception reply holds the output side until its last
// reply byte. Configuration writes are always accepted (cfg_ready is high).
`default_nettype none

module rtu_frame_validate_dispatch_top #(
  parameter int BUFFER_BYTES = rfvd_pkg::BUFFER_BYTES_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire rfvd_pkg::in_word_t         in_data,
  output logic                            out_valid,
  input  wire                             out_stall,
  output rfvd_pkg::out_word_t             out_data,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [rfvd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire [7:0]                       cfg_data
);

  rfvd_pkg::queue_stat_t q_stat;
  rfvd_pkg::frame_rec_t  push_rec, pop_rec;
  logic                  push, pop;

  rfvd_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_rec  (push_rec)
  );

  rfvd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .q_stat   (q_stat)
  );

  rfvd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_rec   (pop_rec),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
